FILE: rtl/adr_env_pkg.sv
// Shared types, codes and constants of the attack-decay-release envelope generator.
`default_nettype none

package adr_env_pkg;

    // Operation codes of an input request.
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VEL_SENS       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_RATE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_FACTOR   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_FACTOR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_THRESHOLD  = 3'd5;

    // Rates and factors are Q0.32; the multiplier takes them in two halves.
    localparam int RATE_W      = 32;
    localparam int MUL_CHUNK_W = 16;

    localparam logic [RATE_W-1:0] ATTACK_RATE_RESET = 32'hFFFF_FFFF;
    localparam logic [RATE_W-1:0] FACTOR_RESET      = 32'h0001_0000;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_DECAY   = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MUL_DEFICIT = 2'd0,
        MUL_STEP    = 2'd1,
        MUL_SHRINK  = 2'd2
    } mul_src_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DEF_HI,
        S_DEF_LO,
        S_PEAK,
        S_STEP_HI,
        S_STEP_LO,
        S_STEP,
        S_SHR_HI,
        S_SHR_LO,
        S_SHRINK,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic     load;
        logic     mul_hi;
        logic     mul_lo;
        mul_src_t mul_src;
        logic     set_peak;
        logic     set_step;
        logic     attack_add;
        logic     shrink;
        logic     clear_level;
        logic     note_off;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        phase_t     phase;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/adr_envelope_generator.sv
// Top level of the attack-decay-release envelope generator.
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_ready     operation, velocity
// output    out_valid / out_ready   level, phase
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Decay and release ticks use the shared multiplier once and a note-on uses it twice (deficit,
// then attack step); note-off, attack and idle ticks and unused codes do not use it. The block
// takes no new request until the current one has emitted its result. Reset clears the envelope
// to idle at zero and loads the register defaults. A result that is not taken holds in the
// output register; the block still accepts the next request and only stalls when that
// request's result is ready to leave.

module adr_envelope_generator #(
    parameter int OUT_FRAC_BITS   = 16,
    parameter int INNER_FRAC_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic [OUT_FRAC_BITS:0]              velocity,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [OUT_FRAC_BITS:0]              level,
    output logic [1:0]                          phase,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adr_env_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adr_env_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import adr_env_pkg::*;

    localparam logic [OUT_FRAC_BITS:0] LEVEL_ONE = {1'b1, {OUT_FRAC_BITS{1'b0}}};

    // Register file outputs.
    logic                   attack_mode;
    logic [OUT_FRAC_BITS:0] velocity_sensitivity;
    logic [RATE_W-1:0]      attack_rate;
    logic [RATE_W-1:0]      decay_factor;
    logic [RATE_W-1:0]      release_factor;
    logic [OUT_FRAC_BITS:0] end_threshold;

    // Controller to datapath, and back.
    dp_cmd_t    cmd;
    dp_status_t status;

    adr_env_cfg #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_cfg (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .attack_mode         (attack_mode),
        .velocity_sensitivity(velocity_sensitivity),
        .attack_rate         (attack_rate),
        .decay_factor        (decay_factor),
        .release_factor      (release_factor),
        .end_threshold       (end_threshold)
    );

    // The controller walks each request through its sequence of datapath steps and
    // owns the output valid flag.
    adr_env_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the level, phase, peak and attack step, the shared
    // multiplier with its accumulator, and the output payload register.
    adr_env_dp #(
        .OUT_FRAC_BITS  (OUT_FRAC_BITS),
        .INNER_FRAC_BITS(INNER_FRAC_BITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .operation           (operation),
        .velocity            (velocity),
        .attack_mode         (attack_mode),
        .velocity_sensitivity(velocity_sensitivity),
        .attack_rate         (attack_rate),
        .decay_factor        (decay_factor),
        .release_factor      (release_factor),
        .end_threshold       (end_threshold),
        .level               (level),
        .phase               (phase)
    );

    // Once a request is taken the block is busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again straight after a request");

    // A result never leaves in the cycle right after its request was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared before the request was processed");

    // The reported level never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level <= LEVEL_ONE))
        else $error("reported level above full scale");

endmodule

`default_nettype wire

FILE: rtl/adr_env_cfg.sv
// Configuration register file of the envelope generator.
`default_nettype none

module adr_env_cfg #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [adr_env_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adr_env_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                attack_mode,
    output logic [OUT_FRAC_BITS:0]              velocity_sensitivity,
    output logic [adr_env_pkg::RATE_W-1:0]      attack_rate,
    output logic [adr_env_pkg::RATE_W-1:0]      decay_factor,
    output logic [adr_env_pkg::RATE_W-1:0]      release_factor,
    output logic [OUT_FRAC_BITS:0]              end_threshold
);
    import adr_env_pkg::*;

    localparam int OW = OUT_FRAC_BITS + 1;

    logic              attack_mode_reg;
    logic [OW-1:0]     vel_sens_reg;
    logic [RATE_W-1:0] attack_rate_reg;
    logic [RATE_W-1:0] decay_factor_reg;
    logic [RATE_W-1:0] release_factor_reg;
    logic [OW-1:0]     end_threshold_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_mode_reg    <= 1'b0;
            vel_sens_reg       <= '0;
            attack_rate_reg    <= ATTACK_RATE_RESET;
            decay_factor_reg   <= FACTOR_RESET;
            release_factor_reg <= FACTOR_RESET;
            end_threshold_reg  <= OW'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ATTACK_MODE:    attack_mode_reg    <= cfg_data[0];
                CFG_VEL_SENS:       vel_sens_reg       <= cfg_data[OW-1:0];
                CFG_ATTACK_RATE:    attack_rate_reg    <= cfg_data;
                CFG_DECAY_FACTOR:   decay_factor_reg   <= cfg_data;
                CFG_RELEASE_FACTOR: release_factor_reg <= cfg_data;
                CFG_END_THRESHOLD:  end_threshold_reg  <= cfg_data[OW-1:0];
                default:            ;
            endcase
        end
    end

    assign attack_mode          = attack_mode_reg;
    assign velocity_sensitivity = vel_sens_reg;
    assign attack_rate          = attack_rate_reg;
    assign decay_factor         = decay_factor_reg;
    assign release_factor       = release_factor_reg;
    assign end_threshold        = end_threshold_reg;

endmodule

`default_nettype wire

FILE: rtl/adr_env_ctrl.sv
// Sequencing state machine and output handshake of the envelope generator.
`default_nettype none

module adr_env_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  adr_env_pkg::dp_status_t status,
    output adr_env_pkg::dp_cmd_t    cmd
);
    import adr_env_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                unique case (status.op)
                    OP_NOTE_ON:  state_next = S_DEF_HI;
                    OP_NOTE_OFF: cmd.note_off = 1'b1;
                    OP_TICK:
                    begin
                        unique case (status.phase) inside
                            PH_ATTACK:            cmd.attack_add = 1'b1;
                            PH_DECAY, PH_RELEASE: state_next = S_SHR_HI;
                            default:              cmd.clear_level = 1'b1;
                        endcase
                    end
                    default: ;
                endcase
            end
            S_DEF_HI:
            begin
                cmd.mul_hi  = 1'b1;
                cmd.mul_src = MUL_DEFICIT;
                state_next  = S_DEF_LO;
            end
            S_DEF_LO:
            begin
                cmd.mul_lo  = 1'b1;
                cmd.mul_src = MUL_DEFICIT;
                state_next  = S_PEAK;
            end
            S_PEAK:
            begin
                cmd.set_peak = 1'b1;
                state_next   = S_STEP_HI;
            end
            S_STEP_HI:
            begin
                cmd.mul_hi  = 1'b1;
                cmd.mul_src = MUL_STEP;
                state_next  = S_STEP_LO;
            end
            S_STEP_LO:
            begin
                cmd.mul_lo  = 1'b1;
                cmd.mul_src = MUL_STEP;
                state_next  = S_STEP;
            end
            S_STEP:
            begin
                cmd.set_step = 1'b1;
                state_next   = S_FINISH;
            end
            S_SHR_HI:
            begin
                cmd.mul_hi  = 1'b1;
                cmd.mul_src = MUL_SHRINK;
                state_next  = S_SHR_LO;
            end
            S_SHR_LO:
            begin
                cmd.mul_lo  = 1'b1;
                cmd.mul_src = MUL_SHRINK;
                state_next  = S_SHRINK;
            end
            S_SHRINK:
            begin
                cmd.shrink = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/adr_env_dp.sv
// Datapath of the envelope generator: envelope state, shared multiplier and result register.
`default_nettype none

module adr_env_dp #(
    parameter int OUT_FRAC_BITS   = 16,
    parameter int INNER_FRAC_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  adr_env_pkg::dp_cmd_t           cmd,
    output adr_env_pkg::dp_status_t        status,
    input  logic [1:0]                     operation,
    input  logic [OUT_FRAC_BITS:0]         velocity,
    input  logic                           attack_mode,
    input  logic [OUT_FRAC_BITS:0]         velocity_sensitivity,
    input  logic [adr_env_pkg::RATE_W-1:0] attack_rate,
    input  logic [adr_env_pkg::RATE_W-1:0] decay_factor,
    input  logic [adr_env_pkg::RATE_W-1:0] release_factor,
    input  logic [OUT_FRAC_BITS:0]         end_threshold,
    output logic [OUT_FRAC_BITS:0]         level,
    output logic [1:0]                     phase
);
    import adr_env_pkg::*;

    localparam int OW      = OUT_FRAC_BITS + 1;
    localparam int LW      = INNER_FRAC_BITS + 1;
    localparam int AW      = (OW > LW) ? OW : LW;
    localparam int PW      = AW + RATE_W;
    localparam int CW      = AW + 1;
    localparam int MW      = AW + MUL_CHUNK_W;
    localparam int SH_UP   = (INNER_FRAC_BITS >= OUT_FRAC_BITS) ?
                             INNER_FRAC_BITS - OUT_FRAC_BITS : 0;
    localparam int SH_DN   = (INNER_FRAC_BITS >= OUT_FRAC_BITS) ?
                             0 : OUT_FRAC_BITS - INNER_FRAC_BITS;
    localparam int STEP_SH = INNER_FRAC_BITS - OUT_FRAC_BITS - RATE_W;
    localparam int STEP_UP = (STEP_SH >= 0) ? STEP_SH : 0;
    localparam int STEP_DN = (STEP_SH < 0) ? -STEP_SH : 0;

    localparam logic [OW-1:0] ONE_OUT    = {1'b1, {OUT_FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (OUT_FRAC_BITS - 1);

    // Envelope state.
    logic [LW-1:0] level_reg, level_next;
    phase_t        phase_reg, phase_next;
    logic [OW-1:0] peak_reg, peak_next;
    logic [LW-1:0] step_reg, step_next;

    // Request and multiplier registers.
    logic [1:0]    op_reg;
    logic [OW-1:0] vel_reg;
    logic [OW-1:0] report_reg;
    logic [PW-1:0] acc_reg, acc_next;
    logic [OW-1:0] out_level_reg;
    phase_t        out_phase_reg;

    logic [OW-1:0]          sens_sat;
    logic [OW-1:0]          vel_sat;
    logic [RATE_W-1:0]      rate_eff;
    logic [RATE_W-1:0]      factor;
    logic [AW-1:0]          mul_a;
    logic [RATE_W-1:0]      mul_b;
    logic [MUL_CHUNK_W-1:0] mul_half;
    logic [MW-1:0]          mul_pp;
    logic [OW-1:0]          report_now;

    logic [PW-1:0] def_sum;
    logic [PW-1:0] def_q;
    logic [OW-1:0] deficit;
    logic [OW-1:0] peak_new;
    logic [LW-1:0] peak_new_in;
    logic [LW-1:0] peak_in;
    logic [LW-1:0] level_on;
    logic [PW-1:0] step_full;
    logic [LW-1:0] step_new;
    logic [LW:0]   att_sum;
    logic [AW-1:0] shr_prod;
    logic [AW-1:0] shr_sub;
    logic [LW-1:0] level_shr;
    logic [CW-1:0] thr_in;

    assign sens_sat = (velocity_sensitivity > ONE_OUT) ? ONE_OUT : velocity_sensitivity;
    assign vel_sat  = (velocity > ONE_OUT) ? ONE_OUT : velocity;
    assign rate_eff = (attack_rate == '0) ? RATE_W'(1) : attack_rate;
    assign factor   = (phase_reg == PH_RELEASE) ? release_factor : decay_factor;

    assign report_now = OW'((AW'(level_reg) << SH_DN) >> SH_UP);

    always_comb
    begin
        case (cmd.mul_src)
            MUL_DEFICIT:
            begin
                mul_a = AW'(ONE_OUT - vel_reg);
                mul_b = RATE_W'(sens_sat);
            end
            MUL_STEP:
            begin
                mul_a = AW'(peak_reg);
                mul_b = rate_eff;
            end
            MUL_SHRINK:
            begin
                mul_a = AW'(level_reg);
                mul_b = factor;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Upper half first, then shift and add the lower half.
    assign mul_half = cmd.mul_hi ? mul_b[RATE_W-1:MUL_CHUNK_W] : mul_b[MUL_CHUNK_W-1:0];
    assign mul_pp   = {{MUL_CHUNK_W{1'b0}}, mul_a} * {{AW{1'b0}}, mul_half};

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.mul_hi)
            acc_next = PW'(mul_pp);
        else if (cmd.mul_lo)
            acc_next = (acc_reg << MUL_CHUNK_W) + PW'(mul_pp);
    end

    // Peak from the rounded velocity deficit.
    assign def_sum     = acc_reg + ROUND_HALF;
    assign def_q       = def_sum >> OUT_FRAC_BITS;
    assign deficit     = (def_q > PW'(ONE_OUT)) ? ONE_OUT : def_q[OW-1:0];
    assign peak_new    = ONE_OUT - deficit;
    assign peak_new_in = LW'((AW'(peak_new) << SH_UP) >> SH_DN);
    assign peak_in     = LW'((AW'(peak_reg) << SH_UP) >> SH_DN);
    assign level_on    = attack_mode ? '0 : level_reg;

    // Attack step, never zero for a nonzero peak.
    assign step_full = (acc_reg << STEP_UP) >> STEP_DN;
    assign step_new  = ((step_full == '0) && (peak_reg != '0)) ? LW'(1) : LW'(step_full);

    assign att_sum = {1'b0, level_reg} + {1'b0, step_reg};

    // Decay and release remove at least one LSB and stop at zero.
    assign shr_prod  = acc_reg[PW-1:RATE_W];
    assign shr_sub   = (shr_prod == '0) ? AW'(1) : shr_prod;
    assign level_shr = (AW'(level_reg) > shr_sub) ? LW'(AW'(level_reg) - shr_sub) : '0;
    assign thr_in    = (CW'(end_threshold) << SH_UP) >> SH_DN;

    always_comb
    begin
        level_next = level_reg;
        phase_next = phase_reg;
        peak_next  = peak_reg;
        step_next  = step_reg;
        if (cmd.set_peak)
        begin
            peak_next  = peak_new;
            level_next = level_on;
            phase_next = (level_on < peak_new_in) ? PH_ATTACK : PH_DECAY;
        end
        if (cmd.set_step)
            step_next = step_new;
        if (cmd.attack_add)
        begin
            if (att_sum >= (LW + 1)'(peak_in))
            begin
                level_next = peak_in;
                phase_next = PH_DECAY;
            end
            else
                level_next = att_sum[LW-1:0];
        end
        if (cmd.shrink)
        begin
            level_next = level_shr;
            if (CW'(level_shr) <= thr_in)
                phase_next = PH_IDLE;
        end
        if (cmd.clear_level)
            level_next = '0;
        if (cmd.note_off && (phase_reg != PH_IDLE))
            phase_next = PH_RELEASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            phase_reg <= PH_IDLE;
            peak_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            phase_reg <= phase_next;
            peak_reg  <= peak_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.load)
        begin
            op_reg     <= operation;
            vel_reg    <= vel_sat;
            report_reg <= report_now;
        end
        if (cmd.emit)
        begin
            out_level_reg <= report_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign status.op    = op_reg;
    assign status.phase = phase_reg;
    assign level        = out_level_reg;
    assign phase        = out_phase_reg;

endmodule

`default_nettype wire
